// ----- hw/rtl/instance_bounds_accumulator_assert.svh -----
// Assertion macros shared by the checker. Each expects clk and arst_n in scope.
`ifndef INSTANCE_BOUNDS_ACCUMULATOR_ASSERT_SVH
`define INSTANCE_BOUNDS_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define IBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ibacc check failed");

// next-cycle implication
`define IBA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ibacc check failed");

`endif

// ----- hw/rtl/ibacc_pkg.sv -----
package ibacc_pkg;

	localparam int WORD_W        = 32;
	localparam int PROD_W        = 2 * WORD_W;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t [2:0]              vec3_t;   // [axis]
	typedef vec3_t [2:0]              mat3_t;   // [column][row]
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef prod_t [2:0]              pvec3_t;
	typedef pvec3_t [2:0]             pmat3_t;  // [column][row]

	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	localparam logic [1:0] COL_TRANSLATION = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MESH_MIN_X = 3'd0,
		REG_MESH_MIN_Y = 3'd1,
		REG_MESH_MIN_Z = 3'd2,
		REG_MESH_MAX_X = 3'd3,
		REG_MESH_MAX_Y = 3'd4,
		REG_MESH_MAX_Z = 3'd5
	} cfg_reg_t;

	// control travelling alongside each beat
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} ctl_t;

endpackage

// ----- hw/rtl/ibacc_cols.sv -----
module ibacc_cols (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [1:0]        column_index,
	input  ibacc_pkg::vec3_t  coef,
	input  logic              first_of_set,
	input  logic              last_of_set,
	output ibacc_pkg::ctl_t   ctl_s1,
	output ibacc_pkg::vec3_t  t_s1,
	output ibacc_pkg::mat3_t  held_q
);
	import ibacc_pkg::*;

	logic accept;
	assign accept = in_valid && adv;

	// linear columns, written as they arrive; contents undefined until then
	always_ff @(posedge clk) begin
		if (accept && column_index != COL_TRANSLATION) begin
			held_q[column_index] <= coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= accept && column_index == COL_TRANSLATION;
			ctl_s1.first <= first_of_set;
			ctl_s1.last  <= last_of_set;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= coef;
		end
	end

endmodule

// ----- hw/rtl/ibacc_mul.sv -----
module ibacc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ibacc_pkg::ctl_t   ctl_s1,
	input  ibacc_pkg::vec3_t  t_s1,
	input  ibacc_pkg::mat3_t  held,
	input  ibacc_pkg::vec3_t  mesh_lo,
	input  ibacc_pkg::vec3_t  mesh_hi,
	output ibacc_pkg::ctl_t   ctl_s2,
	output ibacc_pkg::vec3_t  t_s2,
	output ibacc_pkg::pmat3_t plo_s2,
	output ibacc_pkg::pmat3_t phi_s2
);
	import ibacc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// each matrix element against both box extents of its column's axis
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= t_s1;
			for (int j = 0; j < 3; j++) begin
				for (int r = 0; r < 3; r++) begin
					plo_s2[j][r] <= PROD_W'($signed(held[j][r])) * PROD_W'($signed(mesh_lo[j]));
					phi_s2[j][r] <= PROD_W'($signed(held[j][r])) * PROD_W'($signed(mesh_hi[j]));
				end
			end
		end
	end

endmodule

// ----- hw/rtl/ibacc_reduce.sv -----
module ibacc_reduce #(
	parameter int FRAC_BITS = ibacc_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ibacc_pkg::ctl_t   ctl_s2,
	input  ibacc_pkg::vec3_t  t_s2,
	input  ibacc_pkg::pmat3_t plo_s2,
	input  ibacc_pkg::pmat3_t phi_s2,
	output ibacc_pkg::ctl_t   ctl_s3,
	output ibacc_pkg::vec3_t  nmin_s3,
	output ibacc_pkg::vec3_t  nmax_s3
);
	import ibacc_pkg::*;

	// shifted product width plus two bits of growth for the four-term sum
	localparam int SUM_W = PROD_W - FRAC_BITS + 2;

	typedef logic signed [SUM_W-1:0] sum_t;

	function automatic word_t sat_word(input sum_t v);
		if (v > sum_t'(WORD_MAX)) begin
			return WORD_MAX;
		end else if (v < sum_t'(WORD_MIN)) begin
			return WORD_MIN;
		end
		return WORD_W'(v);
	endfunction

	sum_t  acc_lo [3];
	sum_t  acc_hi [3];
	vec3_t nmin;
	vec3_t nmax;

	// Corner choice per axis is independent and the sum separates, so the
	// corner extreme is the translation plus the per-column extremes.
	always_comb begin
		sum_t a;
		sum_t b;
		for (int r = 0; r < 3; r++) begin
			acc_lo[r] = sum_t'($signed(t_s2[r]));
			acc_hi[r] = sum_t'($signed(t_s2[r]));
			for (int j = 0; j < 3; j++) begin
				a = sum_t'($signed(plo_s2[j][r]) >>> FRAC_BITS);  // floor
				b = sum_t'($signed(phi_s2[j][r]) >>> FRAC_BITS);
				acc_lo[r] = acc_lo[r] + ((a < b) ? a : b);
				acc_hi[r] = acc_hi[r] + ((a < b) ? b : a);
			end
			nmin[r] = sat_word(acc_lo[r]);
			nmax[r] = sat_word(acc_hi[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nmin_s3 <= nmin;
			nmax_s3 <= nmax;
		end
	end

endmodule

// ----- hw/rtl/ibacc_merge.sv -----
module ibacc_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ibacc_pkg::ctl_t   ctl_s3,
	input  ibacc_pkg::vec3_t  nmin_s3,
	input  ibacc_pkg::vec3_t  nmax_s3,
	output logic              out_valid_q,
	output logic              done_q,
	output ibacc_pkg::vec3_t  box_min_q,
	output ibacc_pkg::vec3_t  box_max_q
);
	import ibacc_pkg::*;

	// the union box doubles as the output payload: it only moves on a new beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				box_min_q[r] <= WORD_MAX;
				box_max_q[r] <= WORD_MIN;
			end
		end else if (adv) begin
			out_valid_q <= ctl_s3.valid;
			if (ctl_s3.valid) begin
				done_q <= ctl_s3.last;
				for (int r = 0; r < 3; r++) begin
					if (ctl_s3.first || $signed(nmin_s3[r]) < $signed(box_min_q[r])) begin
						box_min_q[r] <= nmin_s3[r];
					end
					if (ctl_s3.first || $signed(nmax_s3[r]) > $signed(box_max_q[r])) begin
						box_max_q[r] <= nmax_s3[r];
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/instance_bounds_accumulator.sv -----
// Union of instance-transformed mesh boxes. Feed the four columns of each
// instance's affine matrix, one beat per cycle; columns 0 to 2 are held and
// give no result, and the translation column yields one result beat carrying
// the updated union box. The block takes a beat every cycle and is held up
// only while a result waits on out_stall: the whole pipe (input register,
// 18 parallel 32x32 multipliers, reduce and saturate, box merge) moves as
// one. The user must write mesh box registers by index through the cfg port
// only while no result is outstanding; the block does not enforce it.
module instance_bounds_accumulator #(
	parameter int FRAC_BITS = ibacc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ibacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  ibacc_pkg::word_t                  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        column_index,
	input  ibacc_pkg::word_t                  coef_x,
	input  ibacc_pkg::word_t                  coef_y,
	input  ibacc_pkg::word_t                  coef_z,
	input  logic                              first_of_set,
	input  logic                              last_of_set,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ibacc_pkg::word_t                  union_min_x,
	output ibacc_pkg::word_t                  union_min_y,
	output ibacc_pkg::word_t                  union_min_z,
	output ibacc_pkg::word_t                  union_max_x,
	output ibacc_pkg::word_t                  union_max_y,
	output ibacc_pkg::word_t                  union_max_z,
	output logic                              set_done
);
	import ibacc_pkg::*;

	vec3_t  mesh_lo_q;
	vec3_t  mesh_hi_q;
	vec3_t  coef;
	logic   adv;
	ctl_t   ctl_s1;
	ctl_t   ctl_s2;
	ctl_t   ctl_s3;
	vec3_t  t_s1;
	vec3_t  t_s2;
	mat3_t  held;
	pmat3_t plo_s2;
	pmat3_t phi_s2;
	vec3_t  nmin_s3;
	vec3_t  nmax_s3;
	vec3_t  box_min;
	vec3_t  box_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_lo_q <= '0;
			mesh_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MESH_MIN_X: mesh_lo_q[0] <= cfg_data;
				REG_MESH_MIN_Y: mesh_lo_q[1] <= cfg_data;
				REG_MESH_MIN_Z: mesh_lo_q[2] <= cfg_data;
				REG_MESH_MAX_X: mesh_hi_q[0] <= cfg_data;
				REG_MESH_MAX_Y: mesh_hi_q[1] <= cfg_data;
				REG_MESH_MAX_Z: mesh_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipe advances unless a finished result is being held back
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign coef     = {coef_z, coef_y, coef_x};

	ibacc_cols u_cols (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.column_index (column_index),
		.coef         (coef),
		.first_of_set (first_of_set),
		.last_of_set  (last_of_set),
		.ctl_s1       (ctl_s1),
		.t_s1         (t_s1),
		.held_q       (held)
	);

	ibacc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.t_s1    (t_s1),
		.held    (held),
		.mesh_lo (mesh_lo_q),
		.mesh_hi (mesh_hi_q),
		.ctl_s2  (ctl_s2),
		.t_s2    (t_s2),
		.plo_s2  (plo_s2),
		.phi_s2  (phi_s2)
	);

	ibacc_reduce #(
		.FRAC_BITS (FRAC_BITS)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s2  (ctl_s2),
		.t_s2    (t_s2),
		.plo_s2  (plo_s2),
		.phi_s2  (phi_s2),
		.ctl_s3  (ctl_s3),
		.nmin_s3 (nmin_s3),
		.nmax_s3 (nmax_s3)
	);

	ibacc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_s3      (ctl_s3),
		.nmin_s3     (nmin_s3),
		.nmax_s3     (nmax_s3),
		.out_valid_q (out_valid),
		.done_q      (set_done),
		.box_min_q   (box_min),
		.box_max_q   (box_max)
	);

	assign union_min_x = box_min[0];
	assign union_min_y = box_min[1];
	assign union_min_z = box_min[2];
	assign union_max_x = box_max[0];
	assign union_max_y = box_max[1];
	assign union_max_z = box_max[2];

endmodule

// ----- hw/rtl/ibacc_chk.sv -----
`include "instance_bounds_accumulator_assert.svh"

module ibacc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [1:0]                        column_index,
	input logic                              out_valid,
	input logic                              out_stall,
	input ibacc_pkg::word_t                  union_min_x,
	input ibacc_pkg::word_t                  union_max_x,
	input logic                              set_done
);
	import ibacc_pkg::*;

	logic                tr_accept;
	logic [2*WORD_W:0]   out_beat;

	assign tr_accept = in_valid && !in_stall && column_index == COL_TRANSLATION;
	assign out_beat  = {union_min_x, union_max_x, set_done};

	// input is only held off by a result stuck at the output
	`IBA_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

	// a held result keeps its beat
	`IBA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

	// translation column with a free-running pipe reaches the output
	`IBA_ASSERT_NXT(a_latency, tr_accept ##1 !in_stall ##1 !in_stall ##1 !in_stall, out_valid)

endmodule

bind instance_bounds_accumulator ibacc_chk u_ibacc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.column_index (column_index),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.union_min_x  (union_min_x),
	.union_max_x  (union_max_x),
	.set_done     (set_done)
);
